/* sv/utnorm_pkg.sv */
// ----------------------------------------------------------------------------
// utnorm_pkg
// Shared types, codes and character tables for the UTF-8 text normalizer.
// ----------------------------------------------------------------------------
package utnorm_pkg;

  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_QUESTION = 8'h3F;
  localparam logic [2:0] MAX_RESULTS = 3'd6;

  localparam logic [20:0] CP_HARAKAT_LO = 21'h00064B;
  localparam logic [20:0] CP_HARAKAT_HI = 21'h000652;
  localparam logic [20:0] CP_TATWEEL    = 21'h000640;
  localparam logic [20:0] CP_ALEF_HAMZA_ABOVE = 21'h000623;
  localparam logic [20:0] CP_ALEF_HAMZA_BELOW = 21'h000625;
  localparam logic [20:0] CP_ALEF_MADDA = 21'h000622;
  localparam logic [20:0] CP_ALEF       = 21'h000627;
  localparam logic [20:0] CP_TEH_MARBUTA = 21'h000629;
  localparam logic [20:0] CP_HEH        = 21'h000647;
  localparam logic [20:0] CP_ALEF_MAKSURA = 21'h000649;
  localparam logic [20:0] CP_YEH        = 21'h00064A;
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_present;
    logic       last_of_text;
  } out_item_t;

  // controller commands
  typedef struct packed {
    logic load;
    logic decode;
    logic emit;
    logic finish;
  } utnorm_cmd_t;

  // datapath status
  typedef struct packed {
    logic at_end;     // all work bytes consumed
    logic need_more;  // sequence incomplete and text not ending
    logic has_bytes;  // decoded item emits at least one byte
    logic emit_ok;    // a byte can be placed this cycle
    logic emit_final; // this emit is the last of the item
    logic fin_ok;     // output slot free for the closing transfer
  } utnorm_stat_t;

  // Latin-1 letter to ASCII base (NBSP to space), zero when no fold applies
  function automatic logic [7:0] latin_base(input logic [7:0] c);
    logic [7:0] r;
    r = 8'h00;
    if ((c >= 8'hC0 && c <= 8'hC6) || (c >= 8'hE0 && c <= 8'hE6)) r = "a";
    else if (c == 8'hC7 || c == 8'hE7) r = "c";
    else if ((c >= 8'hC8 && c <= 8'hCB) || (c >= 8'hE8 && c <= 8'hEB)) r = "e";
    else if ((c >= 8'hCC && c <= 8'hCF) || (c >= 8'hEC && c <= 8'hEF)) r = "i";
    else if (c == 8'hD1 || c == 8'hF1) r = "n";
    else if ((c >= 8'hD2 && c <= 8'hD6) || c == 8'hD8 ||
             (c >= 8'hF2 && c <= 8'hF6) || c == 8'hF8) r = "o";
    else if ((c >= 8'hD9 && c <= 8'hDC) || (c >= 8'hF9 && c <= 8'hFC)) r = "u";
    else if (c == 8'hDD || c == 8'hFD || c == 8'hFF) r = "y";
    else if (c == 8'hDF) r = "s";
    else if (c == 8'hA0) r = CH_SPACE;
    return r;
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == 8'h20) || (c == 8'h09) || (c == 8'h0A) || (c == 8'h0D) ||
           (c == 8'h0B) || (c == 8'h0C);
  endfunction

endpackage

/* sv/utf8_accent_arabic_text_normalizer_unit.sv */
// ----------------------------------------------------------------------------
// utf8_accent_arabic_text_normalizer_unit
// Strict UTF-8 decoder with accent, Arabic, case and whitespace folding.
// ----------------------------------------------------------------------------
// Takes one byte at a time and works on it to completion before taking the
// next. A step accepts the byte, decodes each code point in turn and emits
// its bytes, including an owed space, and then closes. A stalled output
// holds the step. The last result of each step leaves when the step closes,
// so it carries the end-of-text flag correctly.
module utf8_accent_arabic_text_normalizer_unit (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  utnorm_pkg::in_item_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output utnorm_pkg::out_item_t out_data
);

  utnorm_pkg::utnorm_cmd_t  cmd;
  utnorm_pkg::utnorm_stat_t st;

  utnorm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  utnorm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

/* sv/utnorm_ctrl.sv */
// ----------------------------------------------------------------------------
// utnorm_ctrl
// Sequencer: load one byte, decode and emit items, then close the step.
// ----------------------------------------------------------------------------
module utnorm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  utnorm_pkg::utnorm_stat_t st,
  output utnorm_pkg::utnorm_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_DECODE = 4'b0010,
    S_EMIT   = 4'b0100,
    S_FINISH = 4'b1000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.at_end || st.need_more) begin
          state_next = S_FINISH;
        end else begin
          cmd.decode = 1'b1;
          if (st.has_bytes) state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit = 1'b1;
        if (st.emit_ok && st.emit_final) state_next = S_DECODE;
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        if (st.fin_ok) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

/* sv/utnorm_dp.sv */
// ----------------------------------------------------------------------------
// utnorm_dp
// Work buffer, strict decoder, folding, re-encoder and output staging.
// ----------------------------------------------------------------------------
module utnorm_dp (
  input  logic                     clk,
  input  logic                     rst,
  input  utnorm_pkg::in_item_t     in_data,
  input  utnorm_pkg::utnorm_cmd_t  cmd,
  output utnorm_pkg::utnorm_stat_t st,
  output logic                     out_valid,
  input  logic                     out_ready,
  output utnorm_pkg::out_item_t    out_data
);

  logic [7:0] seq_bytes [3];
  logic [1:0] seq_count;
  logic       space_pending;
  logic       anything_emitted;

  logic [7:0] work [4];
  logic [2:0] k;
  logic [2:0] pos;
  logic       last;

  logic [7:0] enc [4];
  logic [2:0] enc_n;
  logic [1:0] enc_i;

  logic [7:0] hold;
  logic       hold_v;
  logic [2:0] res_cnt;

  // decoder view at the current position
  logic [7:0]  w0, w1, w2, w3;
  logic [2:0]  have;
  logic [2:0]  n;
  logic        lead_bad, short, cont_bad, range_bad;
  logic [20:0] v;
  logic [20:0] cp;
  logic [2:0]  len;
  logic        dec_ok;
  logic [7:0]  ch;
  logic        ch_path;
  logic        removed;
  logic [7:0]  lb;
  logic [7:0]  e0, e1, e2, e3;
  logic [2:0]  en;
  logic        out_free;
  logic [7:0]  emit_b;
  logic        out_load;

  assign w0   = work[pos[1:0]];
  assign w1   = work[pos[1:0] + 2'd1];
  assign w2   = work[pos[1:0] + 2'd2];
  assign w3   = work[pos[1:0] + 2'd3];
  assign have = k - pos;

  always_comb begin
    lead_bad  = 1'b0;
    n         = 3'd1;
    v         = {13'd0, w0};
    cont_bad  = 1'b0;
    range_bad = 1'b0;
    if (w0 < 8'h80) begin
      n = 3'd1;
    end else if (w0 < 8'hC0) begin
      lead_bad = 1'b1;
    end else if (w0 < 8'hE0) begin
      n         = 3'd2;
      v         = {10'd0, w0[4:0], w1[5:0]};
      cont_bad  = (w1[7:6] != 2'b10);
      range_bad = (v < 21'h80);
    end else if (w0 < 8'hF0) begin
      n         = 3'd3;
      v         = {5'd0, w0[3:0], w1[5:0], w2[5:0]};
      cont_bad  = (w1[7:6] != 2'b10) || (w2[7:6] != 2'b10);
      range_bad = (v < 21'h800) || (v >= 21'hD800 && v <= 21'hDFFF);
    end else if (w0 < 8'hF8) begin
      n         = 3'd4;
      v         = {w0[2:0], w1[5:0], w2[5:0], w3[5:0]};
      cont_bad  = (w1[7:6] != 2'b10) || (w2[7:6] != 2'b10) || (w3[7:6] != 2'b10);
      range_bad = (v < 21'h10000) || (v > utnorm_pkg::CP_MAX);
    end else begin
      lead_bad = 1'b1;
    end
    short  = !lead_bad && (have < n);
    dec_ok = !lead_bad && !short && !cont_bad && !range_bad;
  end

  assign st.need_more = short && !last;

  // fold and re-encode the decoded item
  always_comb begin
    cp      = v;
    len     = dec_ok ? n : 3'd1;
    ch      = utnorm_pkg::CH_QUESTION;
    ch_path = 1'b1;
    removed = 1'b0;
    lb      = (v[20:8] == 13'd0) ? utnorm_pkg::latin_base(v[7:0]) : 8'h00;
    e0 = 8'h00; e1 = 8'h00; e2 = 8'h00; e3 = 8'h00; en = 3'd0;
    if (dec_ok) begin
      if (v < 21'h80) begin
        ch = v[7:0];
      end else if (lb != 8'h00) begin
        ch = lb;
      end else begin
        ch_path = 1'b0;
        if ((v >= utnorm_pkg::CP_HARAKAT_LO && v <= utnorm_pkg::CP_HARAKAT_HI) ||
            v == utnorm_pkg::CP_TATWEEL) begin
          removed = 1'b1;
        end
        if (v == utnorm_pkg::CP_ALEF_HAMZA_ABOVE || v == utnorm_pkg::CP_ALEF_HAMZA_BELOW ||
            v == utnorm_pkg::CP_ALEF_MADDA) cp = utnorm_pkg::CP_ALEF;
        if (v == utnorm_pkg::CP_TEH_MARBUTA) cp = utnorm_pkg::CP_HEH;
        if (v == utnorm_pkg::CP_ALEF_MAKSURA) cp = utnorm_pkg::CP_YEH;
      end
    end
    if (ch >= "A" && ch <= "Z") ch = ch + 8'h20;
    if (ch_path) begin
      e0 = ch;
      en = utnorm_pkg::is_space(ch) ? 3'd0 : 3'd1;
    end else if (!removed) begin
      if (cp < 21'h800) begin
        e0 = {3'b110, cp[10:6]};
        e1 = {2'b10, cp[5:0]};
        en = 3'd2;
      end else if (cp < 21'h10000) begin
        e0 = {4'b1110, cp[15:12]};
        e1 = {2'b10, cp[11:6]};
        e2 = {2'b10, cp[5:0]};
        en = 3'd3;
      end else begin
        e0 = {5'b11110, cp[20:18]};
        e1 = {2'b10, cp[17:12]};
        e2 = {2'b10, cp[11:6]};
        e3 = {2'b10, cp[5:0]};
        en = 3'd4;
      end
    end
  end

  assign st.at_end    = (pos == k);
  assign st.has_bytes = (en != 3'd0);

  assign out_free      = !out_valid || out_ready;
  assign st.emit_ok    = !hold_v || out_free || (res_cnt >= utnorm_pkg::MAX_RESULTS);
  assign st.emit_final = !space_pending && ({1'b0, enc_i} == enc_n - 3'd1);
  assign st.fin_ok     = out_free;
  assign emit_b        = space_pending ? utnorm_pkg::CH_SPACE : enc[enc_i];

  // a new transfer enters the output register
  assign out_load = (cmd.emit && st.emit_ok && hold_v &&
                     (res_cnt < utnorm_pkg::MAX_RESULTS)) ||
                    (cmd.finish && st.fin_ok && (hold_v || last));

  always_ff @(posedge clk) begin
    if (rst) begin
      seq_count        <= 2'd0;
      space_pending    <= 1'b0;
      anything_emitted <= 1'b0;
      hold_v           <= 1'b0;
      res_cnt          <= 3'd0;
      out_valid        <= 1'b0;
      k                <= 3'd0;
      pos              <= 3'd0;
      last             <= 1'b0;
      enc_n            <= 3'd0;
      enc_i            <= 2'd0;
    end else begin
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;

      if (cmd.load) begin
        // buffered bytes first, then the new one
        for (int i = 0; i < 3; i++) begin
          work[i] <= (seq_count == 2'(i)) ? in_data.in_byte : seq_bytes[i];
        end
        if (seq_count == 2'd3) work[3] <= in_data.in_byte;
        k       <= {1'b0, seq_count} + 3'd1;
        pos     <= 3'd0;
        last    <= in_data.end_of_text;
        res_cnt <= 3'd0;
      end

      if (cmd.decode) begin
        pos <= pos + len;
        if (ch_path && utnorm_pkg::is_space(ch) && anything_emitted) space_pending <= 1'b1;
        enc[0] <= e0; enc[1] <= e1; enc[2] <= e2; enc[3] <= e3;
        enc_n  <= en;
        enc_i  <= 2'd0;
      end

      if (cmd.emit && st.emit_ok) begin
        if (space_pending) begin
          space_pending <= 1'b0;
        end else begin
          enc_i            <= enc_i + 2'd1;
          anything_emitted <= 1'b1;
        end
        if (res_cnt < utnorm_pkg::MAX_RESULTS) begin
          if (hold_v) begin
            out_data.out_byte     <= hold;
            out_data.byte_present <= 1'b1;
            out_data.last_of_text <= 1'b0;
          end
          hold    <= emit_b;
          hold_v  <= 1'b1;
          res_cnt <= res_cnt + 3'd1;
        end
      end

      if (cmd.finish && st.fin_ok) begin
        for (int i = 0; i < 3; i++) begin
          seq_bytes[i] <= work[pos[1:0] + 2'(i)];
        end
        seq_count <= last ? 2'd0 : ((have > 3'd3) ? 2'd3 : have[1:0]);
        hold_v    <= 1'b0;
        if (hold_v || last) begin
          out_data.out_byte     <= hold_v ? hold : 8'h00;
          out_data.byte_present <= hold_v;
          out_data.last_of_text <= last;
        end
        if (last) begin
          space_pending    <= 1'b0;
          anything_emitted <= 1'b0;
        end
      end
    end
  end

endmodule

/* sv/utnorm_checker.sv */
// ----------------------------------------------------------------------------
// utnorm_checker
// Port-level checks for the text normalizer, bound to the top level.
// ----------------------------------------------------------------------------
module utnorm_checker (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input utnorm_pkg::in_item_t  in_data,
  input logic                  out_valid,
  input logic                  out_ready,
  input utnorm_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // one byte at a time: no transfer right after a transfer
  a_seq: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken during a step");

  a_marker_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_present |-> out_data.last_of_text)
    else $error("bare marker without end flag");

  a_marker_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.byte_present |-> out_data.out_byte == 8'h00)
    else $error("bare marker carries a byte");

endmodule

bind utf8_accent_arabic_text_normalizer_unit utnorm_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

/* verif/utf8_accent_arabic_text_normalizer_unit_tb.sv */
// ----------------------------------------------------------------------------
// utf8_accent_arabic_text_normalizer_unit_tb
// Drives UTF-8 byte streams through the normalizer and compares every output
// transfer with a behavioral prediction of decoding, folding and collapsing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_accent_arabic_text_normalizer_unit_tb;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 40;

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  utnorm_pkg::in_item_t  in_data;
  logic                  out_valid;
  logic                  out_ready;
  utnorm_pkg::out_item_t out_data;

  utf8_accent_arabic_text_normalizer_unit uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // normalizer state mirror
  logic [7:0] held_bytes[3];
  int         held_count;
  logic       owe_space;
  logic       emitted_any;

  utnorm_pkg::in_item_t  pending_bytes[$];
  utnorm_pkg::out_item_t expected_bytes[$];
  int         error_count;
  bit         hold_long;
  int         hold_count;

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic void push_raw(input logic [7:0] b);
    utnorm_pkg::out_item_t o;
    o.out_byte = b; o.byte_present = 1'b1; o.last_of_text = 1'b0;
    expected_bytes.push_back(o);
  endfunction

  function automatic void push_visible(input logic [7:0] b);
    if (owe_space) begin
      push_raw(8'h20);
      owe_space = 1'b0;
    end
    push_raw(b);
    emitted_any = 1'b1;
  endfunction

  function automatic void push_ascii(input logic [7:0] c);
    if (c >= "A" && c <= "Z") c = c + 8'd32;
    if (c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h0D || c == 8'h0B ||
        c == 8'h0C) begin
      if (emitted_any) owe_space = 1'b1;
      return;
    end
    push_visible(c);
  endfunction

  function automatic logic [7:0] fold_latin(input logic [20:0] cp);
    if ((cp >= 'hC0 && cp <= 'hC6) || (cp >= 'hE0 && cp <= 'hE6)) return "a";
    if (cp == 'hC7 || cp == 'hE7) return "c";
    if ((cp >= 'hC8 && cp <= 'hCB) || (cp >= 'hE8 && cp <= 'hEB)) return "e";
    if ((cp >= 'hCC && cp <= 'hCF) || (cp >= 'hEC && cp <= 'hEF)) return "i";
    if (cp == 'hD1 || cp == 'hF1) return "n";
    if ((cp >= 'hD2 && cp <= 'hD6) || cp == 'hD8 || (cp >= 'hF2 && cp <= 'hF6) ||
        cp == 'hF8) return "o";
    if ((cp >= 'hD9 && cp <= 'hDC) || (cp >= 'hF9 && cp <= 'hFC)) return "u";
    if (cp == 'hDD || cp == 'hFD || cp == 'hFF) return "y";
    if (cp == 'hDF) return "s";
    if (cp == 'hA0) return 8'h20;
    return 8'h00;
  endfunction

  function automatic void push_code_point(input logic [20:0] cp);
    logic [7:0] f;
    if (cp < 'h80) begin
      push_ascii(cp[7:0]);
      return;
    end
    f = fold_latin(cp);
    if (f != 8'h00) begin
      push_ascii(f);
      return;
    end
    if ((cp >= utnorm_pkg::CP_HARAKAT_LO && cp <= utnorm_pkg::CP_HARAKAT_HI) ||
        cp == utnorm_pkg::CP_TATWEEL) return;
    if (cp == utnorm_pkg::CP_ALEF_HAMZA_ABOVE || cp == utnorm_pkg::CP_ALEF_HAMZA_BELOW ||
        cp == utnorm_pkg::CP_ALEF_MADDA)
      cp = utnorm_pkg::CP_ALEF;
    if (cp == utnorm_pkg::CP_TEH_MARBUTA) cp = utnorm_pkg::CP_HEH;
    if (cp == utnorm_pkg::CP_ALEF_MAKSURA) cp = utnorm_pkg::CP_YEH;
    if (cp < 'h800) begin
      push_visible({3'b110, cp[10:6]});
      push_visible({2'b10, cp[5:0]});
    end else if (cp < 'h10000) begin
      push_visible({4'b1110, cp[15:12]});
      push_visible({2'b10, cp[11:6]});
      push_visible({2'b10, cp[5:0]});
    end else begin
      push_visible({5'b11110, cp[20:18]});
      push_visible({2'b10, cp[17:12]});
      push_visible({2'b10, cp[11:6]});
      push_visible({2'b10, cp[5:0]});
    end
  endfunction

  // 1 valid, 0 invalid, 2 incomplete
  function automatic int decode_at(input logic [7:0] w[4], input int at, input int have,
                                   output logic [20:0] cp, output int len);
    logic [7:0] b0;
    int n;
    logic [20:0] v;
    b0 = w[at];
    cp = '0; len = 1;
    if (b0 < 8'h80) begin cp = {13'd0, b0}; return 1; end
    if (b0 < 8'hC0) return 0;
    if (b0 < 8'hE0) begin n = 2; v = {16'd0, b0[4:0]}; end
    else if (b0 < 8'hF0) begin n = 3; v = {17'd0, b0[3:0]}; end
    else if (b0 < 8'hF8) begin n = 4; v = {18'd0, b0[2:0]}; end
    else return 0;
    if (have < n) return 2;
    for (int i = 1; i < n; i++) begin
      if (w[at+i][7:6] != 2'b10) return 0;
      v = {v[14:0], w[at+i][5:0]};
    end
    if (n == 2 && v < 'h80) return 0;
    if (n == 3 && (v < 'h800 || (v >= 'hD800 && v <= 'hDFFF))) return 0;
    if (n == 4 && (v < 'h10000 || v > utnorm_pkg::CP_MAX)) return 0;
    cp = v; len = n;
    return 1;
  endfunction

  function automatic void normalize_byte(input utnorm_pkg::in_item_t it);
    logic [7:0]  work[4];
    logic [20:0] cp;
    int k, at, len, r, base;
    utnorm_pkg::out_item_t o;
    base = expected_bytes.size();
    k = 0; at = 0;
    for (int i = 0; i < held_count; i++) begin
      work[k] = held_bytes[i];
      k = k + 1;
    end
    work[k] = it.in_byte;
    k = k + 1;
    while (at < k) begin
      r = decode_at(work, at, k - at, cp, len);
      if (r == 1) begin
        push_code_point(cp);
        at += len;
      end else if (r == 0 || it.end_of_text) begin
        push_ascii(utnorm_pkg::CH_QUESTION);
        at++;
      end else break;
    end
    held_count = k - at;
    for (int i = 0; i < held_count; i++) held_bytes[i] = work[at+i];
    if (it.end_of_text) begin
      if (expected_bytes.size() == base) begin
        o.out_byte = 8'h00; o.byte_present = 1'b0; o.last_of_text = 1'b1;
        expected_bytes.push_back(o);
      end else begin
        o = expected_bytes[$];
        o.last_of_text = 1'b1;
        expected_bytes[expected_bytes.size()-1] = o;
      end
      held_count = 0; owe_space = 1'b0; emitted_any = 1'b0;
    end
  endfunction

  function automatic int pick_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int send_gap;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) normalize_byte(in_data);
      if (send_gap > 0 || pending_bytes.size() == 0) begin
        in_valid <= 1'b0;
        if (send_gap > 0) send_gap <= send_gap - 1;
      end else begin
        in_valid <= 1'b1;
        in_data  <= pending_bytes.pop_front();
        send_gap <= pick_gap();
      end
    end
  end

  // monitor, with its own stall pattern
  int recv_gap;
  always @(posedge clk) begin
    utnorm_pkg::out_item_t exp_item;
    if (rst) begin
      out_ready <= 1'b0;
      recv_gap  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected transfer %h", out_data));
        end else begin
          exp_item = expected_bytes.pop_front();
          if (out_data.out_byte !== exp_item.out_byte)
            report_mismatch($sformatf("out_byte %h, want %h", out_data.out_byte,
                                      exp_item.out_byte));
          if (out_data.byte_present !== exp_item.byte_present)
            report_mismatch($sformatf("byte_present %b, want %b",
                                      out_data.byte_present, exp_item.byte_present));
          if (out_data.last_of_text !== exp_item.last_of_text)
            report_mismatch($sformatf("last_of_text %b, want %b",
                                      out_data.last_of_text, exp_item.last_of_text));
        end
      end
      if (hold_long) out_ready <= 1'b0;
      else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap  <= recv_gap - 1;
      end else begin
        out_ready <= 1'b1;
        recv_gap  <= pick_gap();
      end
    end
  end

  // long hold-off on the output while bytes keep coming
  always @(posedge clk) begin
    if (rst) begin
      hold_long  <= 1'b0;
      hold_count <= 0;
    end else if (hold_count == 200) begin
      hold_long  <= 1'b1;
      hold_count <= hold_count + 1;
    end else if (hold_count == 400) begin
      hold_long  <= 1'b0;
    end else begin
      hold_count <= hold_count + 1;
    end
  end

  // watchdog
  int idle_cycles;
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic eot);
    utnorm_pkg::in_item_t it;
    it.in_byte = b; it.end_of_text = eot;
    pending_bytes.push_back(it);
  endtask

  function automatic logic [7:0] cont_byte();
    return {2'b10, 6'($urandom_range(0, 63))};
  endfunction

  // well-formed sequence with random content, mostly interesting code points
  task automatic queue_char();
    logic [20:0] cp;
    int p;
    p = $urandom_range(0, 9);
    case (p)
      0, 1: cp = 21'($urandom_range(0, 127));
      2: cp = 21'($urandom_range('h09, 'h0D));
      3: cp = 21'($urandom_range('hA0, 'hFF));
      4: cp = 21'($urandom_range('h0620, 'h0655));
      5: cp = 21'($urandom_range('h80, 'h7FF));
      6: cp = 21'($urandom_range('h800, 'hFFFF));
      7: cp = 21'($urandom_range('h10000, 'h10FFFF));
      default: cp = 21'h000020;
    endcase
    if (cp >= 'hD800 && cp <= 'hDFFF) cp = 21'h00E000;
    if (cp < 'h80) queue_byte(cp[7:0], 1'b0);
    else if (cp < 'h800) begin
      queue_byte({3'b110, cp[10:6]}, 1'b0); queue_byte({2'b10, cp[5:0]}, 1'b0);
    end else if (cp < 'h10000) begin
      queue_byte({4'b1110, cp[15:12]}, 1'b0); queue_byte({2'b10, cp[11:6]}, 1'b0);
      queue_byte({2'b10, cp[5:0]}, 1'b0);
    end else begin
      queue_byte({5'b11110, cp[20:18]}, 1'b0); queue_byte({2'b10, cp[17:12]}, 1'b0);
      queue_byte({2'b10, cp[11:6]}, 1'b0); queue_byte({2'b10, cp[5:0]}, 1'b0);
    end
  endtask

  initial begin
    int p;
    error_count = 0;
    held_count = 0; owe_space = 1'b0; emitted_any = 1'b0;
    rst = 1'b1;
    // directed: whitespace trimming, case, latin, NBSP, arabic, bad forms
    queue_byte(8'h20, 1'b0); queue_byte("A", 1'b0); queue_byte(8'h09, 1'b0);
    queue_byte(8'h0A, 1'b0); queue_byte("z", 1'b0); queue_byte(8'h00, 1'b0);
    queue_byte(8'hC3, 1'b0); queue_byte(8'h89, 1'b0);         // E acute
    queue_byte(8'hC2, 1'b0); queue_byte(8'hA0, 1'b0);         // NBSP
    queue_byte(8'hD9, 1'b0); queue_byte(8'h8E, 1'b0);         // fatha, dropped
    queue_byte(8'hD8, 1'b0); queue_byte(8'hA3, 1'b0);         // alef hamza
    queue_byte(8'hC0, 1'b0); queue_byte(8'h80, 1'b0);         // overlong
    queue_byte(8'hED, 1'b0); queue_byte(8'hA0, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'hF4, 1'b0); queue_byte(8'h90, 1'b0); queue_byte(8'h80, 1'b0);
    queue_byte(8'h80, 1'b0); queue_byte(8'hFF, 1'b0);
    queue_byte(8'hF0, 1'b0); queue_byte(8'h9F, 1'b0); queue_byte(8'h98, 1'b1);
    queue_byte(8'h0D, 1'b1);                                  // bare end marker
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // random texts
    while (pending_bytes.size() < 500) begin
      repeat ($urandom_range(1, 25)) begin
        p = $urandom_range(0, 19);
        if (p < 16) queue_char();
        else if (p < 18) queue_byte(8'($urandom_range(0, 255)), 1'b0);
        else begin
          queue_byte(8'($urandom_range(8'hC0, 8'hF7)), 1'b0);
          if ($urandom_range(0, 1)) queue_byte(cont_byte(), 1'b0);
        end
      end
      if ($urandom_range(0, 3) == 0) queue_byte(8'($urandom_range(8'hE0, 8'hF7)), 1'b1);
      else queue_byte(8'($urandom_range(0, 255)), 1'b1);
    end
    wait (pending_bytes.size() == 0 && !in_valid);
    wait (expected_bytes.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && expected_bytes.size() == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
